[hdl/gads_pkg.sv]
`timescale 1ns / 1ps

package gads_pkg;

    localparam int TRIG_W     = 16;
    localparam int AXIS_W     = 16;
    localparam int DEAD_W     = 15;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int TDEN_W     = TRIG_W + 1;

    typedef enum logic [2:0] {
        REG_LEFT_TRIG_THR  = 3'd0,
        REG_RIGHT_TRIG_THR = 3'd1,
        REG_LEFT_INVERT_Y  = 3'd2,
        REG_RIGHT_INVERT_Y = 3'd3,
        REG_LEFT_INNER     = 3'd4,
        REG_LEFT_OUTER     = 3'd5,
        REG_RIGHT_INNER    = 3'd6,
        REG_RIGHT_OUTER    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]        left_trigger_raw;
        logic [TRIG_W-1:0]        right_trigger_raw;
        logic signed [AXIS_W-1:0] left_x_raw;
        logic signed [AXIS_W-1:0] left_y_raw;
        logic signed [AXIS_W-1:0] right_x_raw;
        logic signed [AXIS_W-1:0] right_y_raw;
    } in_t;

    typedef struct packed {
        logic [TRIG_W-1:0]        left_trigger_level;
        logic [TRIG_W-1:0]        right_trigger_level;
        logic signed [AXIS_W-1:0] left_x_clamped;
        logic signed [AXIS_W-1:0] left_y_clamped;
        logic signed [AXIS_W-1:0] right_x_clamped;
        logic signed [AXIS_W-1:0] right_y_clamped;
        logic signed [AXIS_W-1:0] left_x_shaped;
        logic signed [AXIS_W-1:0] left_y_shaped;
        logic signed [AXIS_W-1:0] right_x_shaped;
        logic signed [AXIS_W-1:0] right_y_shaped;
    } out_t;

endpackage

[hdl/gads_delay.sv]
`timescale 1ns / 1ps

module gads_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < D; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[D-1];

endmodule

[hdl/gads_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. rem_in must be below den_in.
module gads_div #(
    parameter int DW = 17,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] lo_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo_out
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] lo_next  [QW];
    logic [QW-1:0] quo_next [QW];

    always_comb begin
        logic [DW-1:0] rp;
        logic [QW-1:0] lp;
        logic [DW-1:0] dp;
        logic [QW-1:0] qp;
        logic [DW:0]   sh;
        for (int i = 0; i < QW; i++) begin
            rp = (i == 0) ? rem_in : rem_reg[(i == 0) ? 0 : i-1];
            lp = (i == 0) ? lo_in  : lo_reg[(i == 0) ? 0 : i-1];
            dp = (i == 0) ? den_in : den_reg[(i == 0) ? 0 : i-1];
            qp = (i == 0) ? '0     : quo_reg[(i == 0) ? 0 : i-1];
            sh = {rp, lp[QW-1]};
            lo_next[i] = {lp[QW-2:0], 1'b0};
            if (sh >= {1'b0, dp}) begin
                rem_next[i] = DW'(sh - {1'b0, dp});
                quo_next[i] = {qp[QW-2:0], 1'b1};
            end else begin
                rem_next[i] = sh[DW-1:0];
                quo_next[i] = {qp[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QW; i++) begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                den_reg[i] <= (i == 0) ? den_in : den_reg[(i == 0) ? 0 : i-1];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quo_out = quo_reg[QW-1];

endmodule

[hdl/gads_sqrt.sv]
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one root bit per stage.
module gads_sqrt #(
    parameter int RW = 17
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RW-1:0] rad_in,
    output logic [RW-1:0]   root_out
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW-1:0]   root_reg [RW];

    logic [RW+1:0]   rem_next  [RW];
    logic [RW-1:0]   root_next [RW];

    always_comb begin
        logic [RW+1:0]   rp;
        logic [2*RW-1:0] ap;
        logic [RW-1:0]   op;
        logic [RW+3:0]   sh;
        logic [RW+3:0]   trial;
        for (int i = 0; i < RW; i++) begin
            rp = (i == 0) ? '0     : rem_reg[(i == 0) ? 0 : i-1];
            ap = (i == 0) ? rad_in : rad_reg[(i == 0) ? 0 : i-1];
            op = (i == 0) ? '0     : root_reg[(i == 0) ? 0 : i-1];
            sh = {rp, ap[2*RW-1:2*RW-2]};
            trial = {2'b00, op, 2'b01};
            if (sh >= trial) begin
                rem_next[i]  = (RW+2)'(sh - trial);
                root_next[i] = {op[RW-2:0], 1'b1};
            end else begin
                rem_next[i]  = sh[RW+1:0];
                root_next[i] = {op[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < RW; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= (i == 0) ? {rad_in[2*RW-3:0], 2'b00}
                                        : {rad_reg[(i == 0) ? 0 : i-1][2*RW-3:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[RW-1];

endmodule

[hdl/gads_stick.sv]
`timescale 1ns / 1ps

module gads_stick import gads_pkg::*; #(
    parameter int FB = 14
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [AXIS_W-1:0] x_raw,
    input  logic signed [AXIS_W-1:0] y_raw,
    input  logic                     invert_y,
    input  logic [DEAD_W-1:0]        inner,
    input  logic [DEAD_W-1:0]        outer,
    output logic signed [AXIS_W-1:0] x_clamped,
    output logic signed [AXIS_W-1:0] y_clamped,
    output logic signed [AXIS_W-1:0] x_shaped,
    output logic signed [AXIS_W-1:0] y_shaped
);

    localparam int AW  = (FB + 2 > 17) ? FB + 2 : 17;
    localparam int MW  = AW - 1;
    localparam int RW  = AW;
    localparam int PW  = MW + FB + 1;
    localparam int OW  = (FB + 2 > AXIS_W) ? FB + 2 : AXIS_W;
    localparam int LAT = AW + 2 * FB + 7;
    localparam logic signed [AW-1:0] ONE_A = AW'(1) <<< FB;
    localparam logic signed [AW:0]   ONE_R = (AW+1)'(1) <<< FB;

    // stage 1: clamp and invert
    logic signed [AW-1:0] x1_reg, y1_reg, x1_next, y1_next;

    always_comb begin
        logic signed [AW-1:0] xs, ys;
        xs = AW'(x_raw);
        ys = AW'(y_raw);
        if (xs > ONE_A)       x1_next = ONE_A;
        else if (xs < -ONE_A) x1_next = -ONE_A;
        else                  x1_next = xs;
        if (ys > ONE_A)       ys = ONE_A;
        else if (ys < -ONE_A) ys = -ONE_A;
        y1_next = invert_y ? -ys : ys;
    end

    // stage 2: squares
    logic [2*MW-1:0] sqx_reg, sqy_reg;
    logic [MW-1:0]   ax1, ay1;
    logic signed [AW-1:0] ax1_w, ay1_w;

    assign ax1_w = (x1_reg < 0) ? -x1_reg : x1_reg;
    assign ay1_w = (y1_reg < 0) ? -y1_reg : y1_reg;
    assign ax1   = ax1_w[MW-1:0];
    assign ay1   = ay1_w[MW-1:0];

    // stage 3: sum of squares
    logic [2*MW:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            sqx_reg <= (2*MW)'(ax1) * (2*MW)'(ax1);
            sqy_reg <= (2*MW)'(ay1) * (2*MW)'(ay1);
            sum_reg <= (2*MW+1)'(sqx_reg) + (2*MW+1)'(sqy_reg);
        end
    end

    logic [RW-1:0] mag;

    gads_sqrt #(.RW(RW)) u_sqrt (
        .aclk    (aclk),
        .en      (en),
        .rad_in  ((2*RW)'(sum_reg)),
        .root_out(mag)
    );

    // stage D: dead-zone tests and remaining range
    logic [AW-1:0] d_reg, rng_reg, magd_reg;
    logic          sat_reg, inside_reg;

    always_ff @(posedge aclk) begin
        logic signed [AW:0] rng;
        logic [AW-1:0]      dd;
        if (en) begin
            rng = ONE_R - (AW+1)'(outer) - (AW+1)'(inner);
            dd  = mag - AW'(inner);
            d_reg      <= dd;
            rng_reg    <= rng[AW-1:0];
            magd_reg   <= mag;
            inside_reg <= (mag <= AW'(inner));
            // capped at one whenever the excess reaches the full range
            sat_reg    <= (rng <= 0) || ((AW+1)'(dd) >= rng);
        end
    end

    logic [FB-1:0] mfrac;

    gads_div #(.DW(AW), .QW(FB)) u_div_m (
        .aclk   (aclk),
        .en     (en),
        .rem_in (d_reg),
        .lo_in  ('0),
        .den_in (rng_reg),
        .quo_out(mfrac)
    );

    logic [AW+1:0] sd_q;

    gads_delay #(.W(AW + 2), .D(FB)) u_dly_side (
        .aclk(aclk),
        .en  (en),
        .d   ({magd_reg, sat_reg, inside_reg}),
        .q   (sd_q)
    );

    logic signed [AW-1:0] xe, ye;

    gads_delay #(.W(2 * AW), .D(3 + RW + FB)) u_dly_xy (
        .aclk(aclk),
        .en  (en),
        .d   ({x1_reg, y1_reg}),
        .q   ({xe, ye})
    );

    // stage E: scale each component by m
    logic [PW-1:0]  px_reg, py_reg;
    logic [AW-1:0]  mage_reg;
    logic           inse_reg, negx_reg, negy_reg;
    logic [FB:0]    m_val;
    logic signed [AW-1:0] axe_w, aye_w;

    assign m_val = sd_q[1] ? ONE_R[FB:0] : {1'b0, mfrac};
    assign axe_w = (xe < 0) ? -xe : xe;
    assign aye_w = (ye < 0) ? -ye : ye;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= PW'(axe_w[MW-1:0]) * PW'(m_val);
            py_reg   <= PW'(aye_w[MW-1:0]) * PW'(m_val);
            mage_reg <= sd_q[AW+1:2];
            inse_reg <= sd_q[0];
            negx_reg <= xe < 0;
            negy_reg <= ye < 0;
        end
    end

    logic [FB:0] qx, qy;

    gads_div #(.DW(AW), .QW(FB + 1)) u_div_x (
        .aclk   (aclk),
        .en     (en),
        .rem_in (AW'(px_reg[PW-1:FB+1])),
        .lo_in  (px_reg[FB:0]),
        .den_in (mage_reg),
        .quo_out(qx)
    );

    gads_div #(.DW(AW), .QW(FB + 1)) u_div_y (
        .aclk   (aclk),
        .en     (en),
        .rem_in (AW'(py_reg[PW-1:FB+1])),
        .lo_in  (py_reg[FB:0]),
        .den_in (mage_reg),
        .quo_out(qy)
    );

    logic [2:0] fl_q;

    gads_delay #(.W(3), .D(FB + 1)) u_dly_flags (
        .aclk(aclk),
        .en  (en),
        .d   ({inse_reg, negx_reg, negy_reg}),
        .q   (fl_q)
    );

    // stage F: restore sign, zero the output inside the inner dead zone
    logic signed [AXIS_W-1:0] xs_reg, ys_reg;

    always_ff @(posedge aclk) begin
        logic signed [OW-1:0] vx, vy;
        if (en) begin
            vx = OW'(qx);
            vy = OW'(qy);
            if (fl_q[1]) vx = -vx;
            if (fl_q[0]) vy = -vy;
            xs_reg <= fl_q[2] ? '0 : vx[AXIS_W-1:0];
            ys_reg <= fl_q[2] ? '0 : vy[AXIS_W-1:0];
        end
    end

    logic [2*AW-1:0] clq;

    gads_delay #(.W(2 * AW), .D(LAT - 1)) u_dly_clamp (
        .aclk(aclk),
        .en  (en),
        .d   ({x1_reg, y1_reg}),
        .q   (clq)
    );

    assign x_clamped = clq[AW+AXIS_W-1:AW];
    assign y_clamped = clq[AXIS_W-1:0];
    assign x_shaped  = xs_reg;
    assign y_shaped  = ys_reg;

endmodule

[hdl/gamepad_axis_dead_zone_shaper_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Ports                        Payload
// input     in         s_valid s_ready s_data       in_t (triggers, raw stick axes)
// result    out        m_valid m_ready m_data       out_t (levels, clamped, shaped)
// config    in/out     psel penable pwrite paddr    pwdata / prdata, pready tied high
//
// One sample enters per cycle unless the output is stalled; the pipeline depth,
// with AW = max(FRACTION_BITS + 2, 17), is set by the bit-per-stage square root
// and the chained restoring dividers of the stick path.
// Synchronous active-low reset clears the valid chain and the config registers.
// A stalled output freezes the whole pipeline; s_ready follows that stall.
module gamepad_axis_dead_zone_shaper_core import gads_pkg::*; #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW  = (FRACTION_BITS + 2 > 17) ? FRACTION_BITS + 2 : 17;
    localparam int LAT = AW + 2 * FRACTION_BITS + 7;
    localparam int TLAT = TRIG_W + 1;

    // configuration registers
    logic [TRIG_W-1:0] lthr_reg, rthr_reg;
    logic              linv_reg, rinv_reg;
    logic [DEAD_W-1:0] linner_reg, louter_reg, rinner_reg, router_reg;
    cfg_idx_t          cidx;

    assign pready = 1'b1;
    assign cidx   = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lthr_reg   <= '0;
            rthr_reg   <= '0;
            linv_reg   <= 1'b0;
            rinv_reg   <= 1'b0;
            linner_reg <= '0;
            louter_reg <= '0;
            rinner_reg <= '0;
            router_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (cidx)
                REG_LEFT_TRIG_THR:  lthr_reg   <= pwdata[TRIG_W-1:0];
                REG_RIGHT_TRIG_THR: rthr_reg   <= pwdata[TRIG_W-1:0];
                REG_LEFT_INVERT_Y:  linv_reg   <= pwdata[0];
                REG_RIGHT_INVERT_Y: rinv_reg   <= pwdata[0];
                REG_LEFT_INNER:     linner_reg <= pwdata[DEAD_W-1:0];
                REG_LEFT_OUTER:     louter_reg <= pwdata[DEAD_W-1:0];
                REG_RIGHT_INNER:    rinner_reg <= pwdata[DEAD_W-1:0];
                REG_RIGHT_OUTER:    router_reg <= pwdata[DEAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cidx)
            REG_LEFT_TRIG_THR:  prdata = CFG_DATA_W'(lthr_reg);
            REG_RIGHT_TRIG_THR: prdata = CFG_DATA_W'(rthr_reg);
            REG_LEFT_INVERT_Y:  prdata = CFG_DATA_W'(linv_reg);
            REG_RIGHT_INVERT_Y: prdata = CFG_DATA_W'(rinv_reg);
            REG_LEFT_INNER:     prdata = CFG_DATA_W'(linner_reg);
            REG_LEFT_OUTER:     prdata = CFG_DATA_W'(louter_reg);
            REG_RIGHT_INNER:    prdata = CFG_DATA_W'(rinner_reg);
            REG_RIGHT_OUTER:    prdata = CFG_DATA_W'(router_reg);
            default:            prdata = '0;
        endcase
    end

    // pipeline control: whole pipe advances unless the result is held
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // triggers
    logic [TRIG_W-1:0] ldiff_reg, rdiff_reg;
    logic [TDEN_W-1:0] lden_reg, rden_reg;
    logic              lzero_reg, rzero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ldiff_reg <= s_data.left_trigger_raw - lthr_reg;
            rdiff_reg <= s_data.right_trigger_raw - rthr_reg;
            lden_reg  <= (TDEN_W'(1) << TRIG_W) - TDEN_W'(lthr_reg);
            rden_reg  <= (TDEN_W'(1) << TRIG_W) - TDEN_W'(rthr_reg);
            lzero_reg <= s_data.left_trigger_raw <= lthr_reg;
            rzero_reg <= s_data.right_trigger_raw <= rthr_reg;
        end
    end

    logic [TRIG_W-1:0] lq, rq, ltl, rtl;
    logic [1:0]        tz;

    // excess is below the divisor, so the quotient always fits 16 bits
    gads_div #(.DW(TDEN_W), .QW(TRIG_W)) u_div_lt (
        .aclk   (aclk),
        .en     (en),
        .rem_in ({1'b0, ldiff_reg}),
        .lo_in  ('0),
        .den_in (lden_reg),
        .quo_out(lq)
    );

    gads_div #(.DW(TDEN_W), .QW(TRIG_W)) u_div_rt (
        .aclk   (aclk),
        .en     (en),
        .rem_in ({1'b0, rdiff_reg}),
        .lo_in  ('0),
        .den_in (rden_reg),
        .quo_out(rq)
    );

    gads_delay #(.W(2), .D(TRIG_W)) u_dly_tz (
        .aclk(aclk),
        .en  (en),
        .d   ({lzero_reg, rzero_reg}),
        .q   (tz)
    );

    gads_delay #(.W(2 * TRIG_W), .D(LAT - TLAT)) u_dly_trig (
        .aclk(aclk),
        .en  (en),
        .d   ({tz[1] ? '0 : lq, tz[0] ? '0 : rq}),
        .q   ({ltl, rtl})
    );

    // sticks
    gads_stick #(.FB(FRACTION_BITS)) u_left (
        .aclk     (aclk),
        .en       (en),
        .x_raw    (s_data.left_x_raw),
        .y_raw    (s_data.left_y_raw),
        .invert_y (linv_reg),
        .inner    (linner_reg),
        .outer    (louter_reg),
        .x_clamped(m_data.left_x_clamped),
        .y_clamped(m_data.left_y_clamped),
        .x_shaped (m_data.left_x_shaped),
        .y_shaped (m_data.left_y_shaped)
    );

    gads_stick #(.FB(FRACTION_BITS)) u_right (
        .aclk     (aclk),
        .en       (en),
        .x_raw    (s_data.right_x_raw),
        .y_raw    (s_data.right_y_raw),
        .invert_y (rinv_reg),
        .inner    (rinner_reg),
        .outer    (router_reg),
        .x_clamped(m_data.right_x_clamped),
        .y_clamped(m_data.right_y_clamped),
        .x_shaped (m_data.right_x_shaped),
        .y_shaped (m_data.right_y_shaped)
    );

    assign m_data.left_trigger_level  = ltl;
    assign m_data.right_trigger_level = rtl;

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a held result");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transfer missing from valid chain");

    a_hold_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(vld_reg) && $stable(m_data)))
        else $error("pipeline moved during output stall");

endmodule
